FILE: src/dtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_pkg: shared types, constants and byte classification
// Character constants, scanner states, token classes and the entry format
// carried between the scanner front end and the result sequencer.
// ----------------------------------------------------------------------------
package dtt_pkg;

	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_Z    = 8'h7A;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_BTICK   = 8'h60;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		CLS_LETTER = 2'd0,
		CLS_NUMBER = 2'd1,
		CLS_PUNCT  = 2'd2,
		CLS_SPACE  = 2'd3
	} tok_class_t;

	typedef enum logic [2:0] {
		KIND_LETTER,
		KIND_DIGIT,
		KIND_PUNCT,
		KIND_SPACE,
		KIND_OTHER
	} byte_kind_t;

	typedef enum logic [2:0] {
		ST_START    = 3'd0,
		ST_LETTERS  = 3'd1,
		ST_PUNCT    = 3'd2,
		ST_SPACE    = 3'd3,
		ST_INT      = 3'd4,
		ST_HELD_DOT = 3'd5,
		ST_FRAC     = 3'd6
	} scan_state_t;

	typedef struct packed {
		logic [7:0] chr;
		tok_class_t cls;
		logic       start;
	} result_t;

	// One queue entry holds every result caused by one input byte.
	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    two;
	} entry_t;

	function automatic byte_kind_t byte_kind(input logic [7:0] c);
		byte_kind_t k;
		if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) begin
			k = KIND_LETTER;
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			k = KIND_DIGIT;
		end else if ((c >= CH_BANG && c <= CH_SLASH) || (c >= CH_COLON && c <= CH_AT) ||
			(c >= CH_LBRACK && c <= CH_BTICK) || (c >= CH_LBRACE && c <= CH_TILDE)) begin
			k = KIND_PUNCT;
		end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
			k = KIND_SPACE;
		end else begin
			k = KIND_OTHER;
		end
		return k;
	endfunction

	function automatic tok_class_t class_of(input scan_state_t st);
		tok_class_t cls;
		unique case (st)
			ST_LETTERS: cls = CLS_LETTER;
			ST_PUNCT:   cls = CLS_PUNCT;
			ST_SPACE:   cls = CLS_SPACE;
			default:    cls = CLS_NUMBER;
		endcase
		return cls;
	endfunction

	// State entered when a byte opens a new token.
	function automatic scan_state_t fresh_state(input byte_kind_t k);
		scan_state_t st;
		unique case (k)
			KIND_LETTER: st = ST_LETTERS;
			KIND_DIGIT:  st = ST_INT;
			KIND_PUNCT:  st = ST_PUNCT;
			KIND_SPACE:  st = ST_SPACE;
			default:     st = ST_START;
		endcase
		return st;
	endfunction

	// True when the byte extends the token that is open in state st.
	function automatic logic continues(input scan_state_t st, input byte_kind_t k,
		input logic is_dot);
		logic cont;
		unique case (st)
			ST_LETTERS: cont = (k == KIND_LETTER);
			ST_PUNCT:   cont = (k == KIND_PUNCT);
			ST_SPACE:   cont = (k == KIND_SPACE);
			ST_INT:     cont = (k == KIND_DIGIT) || is_dot;
			ST_FRAC:    cont = (k == KIND_DIGIT);
			default:    cont = 1'b0;
		endcase
		return cont;
	endfunction

endpackage

FILE: src/dtt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_front: scanner state machine
// Classifies each transferred byte, advances the longest-match state and
// builds one queue entry with every result that the byte causes.
// ----------------------------------------------------------------------------
module dtt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      ch,
	input  logic            end_of_text,
	output logic            wr_en,
	output dtt_pkg::entry_t wr_entry
);

	dtt_pkg::scan_state_t state_q;
	dtt_pkg::scan_state_t state_d;
	dtt_pkg::scan_state_t eff_st;
	dtt_pkg::scan_state_t scan_nx;
	dtt_pkg::byte_kind_t  kind;
	logic                 is_dot;
	logic                 is_digit;
	logic                 held;
	logic                 cont;
	logic                 emit_pre;
	logic                 emit_c;
	logic                 emit_post;
	dtt_pkg::result_t     pre_res;
	dtt_pkg::result_t     c_res;
	dtt_pkg::result_t     post_res;

	assign kind     = dtt_pkg::byte_kind(ch);
	assign is_dot   = (ch == dtt_pkg::CH_DOT);
	assign is_digit = (kind == dtt_pkg::KIND_DIGIT);
	assign held     = (state_q == dtt_pkg::ST_HELD_DOT);

	// A held dot either joins the number as a fraction or is released as
	// punctuation, after which the byte is scanned as if punctuation were open.
	assign eff_st  = held ? (is_digit ? dtt_pkg::ST_FRAC : dtt_pkg::ST_PUNCT) : state_q;
	assign cont    = dtt_pkg::continues(eff_st, kind, is_dot);
	assign scan_nx = cont ? ((eff_st == dtt_pkg::ST_INT && !is_digit) ?
		dtt_pkg::ST_HELD_DOT : eff_st) : dtt_pkg::fresh_state(kind);

	// Next state.
	always_comb begin
		state_d = state_q;
		if (take) begin
			state_d = end_of_text ? dtt_pkg::ST_START : scan_nx;
		end
	end

	// Entry contents.
	always_comb begin
		emit_pre      = held;
		pre_res.chr   = dtt_pkg::CH_DOT;
		pre_res.cls   = is_digit ? dtt_pkg::CLS_NUMBER : dtt_pkg::CLS_PUNCT;
		pre_res.start = !is_digit;

		emit_c      = cont ? (scan_nx != dtt_pkg::ST_HELD_DOT) : (kind != dtt_pkg::KIND_OTHER);
		c_res.chr   = ch;
		c_res.cls   = dtt_pkg::class_of(scan_nx);
		c_res.start = !cont;

		emit_post      = end_of_text && (scan_nx == dtt_pkg::ST_HELD_DOT);
		post_res.chr   = dtt_pkg::CH_DOT;
		post_res.cls   = dtt_pkg::CLS_PUNCT;
		post_res.start = 1'b1;

		wr_en          = take && (emit_pre || emit_c || emit_post);
		wr_entry.two   = emit_pre && emit_c;
		wr_entry.r1    = c_res;
		if (emit_pre) begin
			wr_entry.r0 = pre_res;
		end else if (emit_c) begin
			wr_entry.r0 = c_res;
		end else begin
			wr_entry.r0 = post_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtt_pkg::ST_START;
		end else begin
			state_q <= state_d;
		end
	end

	a_eot_closes: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_of_text |=> state_q == dtt_pkg::ST_START)
		else $error("token still open after end of text");

	a_two_from_held: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && wr_entry.two |-> held && is_digit == (wr_entry.r0.cls == dtt_pkg::CLS_NUMBER))
		else $error("two results without a held dot");

endmodule

FILE: src/dtt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_queue: entry queue between scanner and result sequencer
// A short first-in first-out store of entries so that either side can stall.
// ----------------------------------------------------------------------------
module dtt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  dtt_pkg::entry_t wr_entry,
	input  logic            rd_en,
	output dtt_pkg::entry_t head,
	output logic            q_empty,
	output logic            q_full
);

	dtt_pkg::entry_t             slots_q [dtt_pkg::QDEPTH];
	logic [dtt_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [dtt_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [dtt_pkg::QPTR_W:0]    count_q;

	assign head    = slots_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == (dtt_pkg::QPTR_W+1)'(dtt_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers wrap naturally because the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && q_full && !rd_en) && !(rd_en && q_empty))
		else $error("queue written while full or read while empty");

endmodule

FILE: src/dtt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_back: result sequencer
// Presents the results of the head entry one per transfer and releases the
// entry after its final result.
// ----------------------------------------------------------------------------
module dtt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dtt_pkg::entry_t  head,
	input  logic             q_empty,
	input  logic             pop,
	output logic             rd_en,
	output dtt_pkg::result_t res,
	output logic             res_last
);

	logic idx_q;
	logic xfer;

	assign xfer     = pop && !q_empty;
	assign res      = idx_q ? head.r1 : head.r0;
	assign res_last = idx_q || !head.two;
	assign rd_en    = xfer && res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 1'b0;
		end else if (xfer) begin
			idx_q <= !res_last;
		end
	end

	a_second_valid: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> !q_empty && head.two)
		else $error("second result selected without a two-result entry");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !res_last |=> idx_q && $stable(head))
		else $error("head entry changed before its second result");

endmodule

FILE: src/dfa_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfa_text_tokenizer: streaming longest-match text lexer
// Splits a byte stream into letter, number, punctuation and whitespace
// tokens and emits each kept byte with its class and a token-start flag.
// ----------------------------------------------------------------------------
// The block takes one byte per clock whenever full is low and delivers one
// result per clock while pop is high and empty is low. The scanner handles
// each byte in the cycle of its transfer and places all of its results, at
// most two, in a four-entry queue; the entry is registered at the transfer
// and its results reach the output once it is at the head. A byte that
// causes two results (a held '.' released together with the next byte)
// needs two result transfers, so the output side sets the sustained rate
// when such bytes are frequent; bytes that cause no result never enter the
// queue. The final result of every byte that causes a result carries last.
module dfa_text_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] ch,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic [1:0] token_class,
	output logic       token_start,
	output logic       last
);

	logic             take;
	logic             wr_en;
	logic             rd_en;
	dtt_pkg::entry_t  wr_entry;
	dtt_pkg::entry_t  head;
	dtt_pkg::result_t res;

	assign take = push && !full;

	dtt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.ch         (ch),
		.end_of_text(end_of_text),
		.wr_en      (wr_en),
		.wr_entry   (wr_entry)
	);

	dtt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_entry(wr_entry),
		.rd_en   (rd_en),
		.head    (head),
		.q_empty (empty),
		.q_full  (full)
	);

	dtt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (empty),
		.pop     (pop),
		.rd_en   (rd_en),
		.res     (res),
		.res_last(last)
	);

	assign out_char    = res.chr;
	assign token_class = res.cls;
	assign token_start = res.start;

endmodule

FILE: sim/dfa_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfa_text_tokenizer_tb: self-checking testbench for the text lexer
// A queue of text bytes feeds a clocked driver that predicts the expected
// token bytes at every transfer. A clocked monitor pops results and checks
// each one against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module dfa_text_tokenizer_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 50;
	localparam int RANDOM_BYTES   = 1000;

	typedef struct packed {
		logic [7:0] c;
		logic       eot;
	} text_byte_t;

	typedef struct packed {
		logic [7:0]          chr;
		dtt_pkg::tok_class_t cls;
		logic                start;
		logic                last;
	} lexeme_byte_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       push        = 1'b0;
	logic       full;
	logic [7:0] ch          = 8'h00;
	logic       end_of_text = 1'b0;
	logic       empty;
	logic       pop         = 1'b0;
	logic [7:0] out_char;
	logic [1:0] token_class;
	logic       token_start;
	logic       last;

	text_byte_t           text_queue[$];
	lexeme_byte_t         expected_bytes[$];
	dtt_pkg::scan_state_t lex_state = dtt_pkg::ST_START;
	int                   error_count = 0;
	int                   cycle_count = 0;
	int                   stall_count = 0;
	logic                 calm;

	dfa_text_tokenizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.ch          (ch),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.token_class (token_class),
		.token_start (token_start),
		.last        (last)
	);

	always #5 clk = ~clk;

	// A window in the middle of the run where neither side idles.
	assign calm = (cycle_count >= 400) && (cycle_count < 800);

	function automatic dtt_pkg::byte_kind_t kind_of_byte(input logic [7:0] c);
		logic [7:0]          folded;
		dtt_pkg::byte_kind_t k;
		folded = c | 8'h20;
		if (c >= 8'h40 && folded >= dtt_pkg::CH_LO_A &&
			folded <= dtt_pkg::CH_LO_Z) begin
			k = dtt_pkg::KIND_LETTER;
		end else if (c >= dtt_pkg::CH_ZERO && c <= dtt_pkg::CH_NINE) begin
			k = dtt_pkg::KIND_DIGIT;
		end else if (c == dtt_pkg::CH_SPACE ||
			(c >= dtt_pkg::CH_TAB && c <= dtt_pkg::CH_CR)) begin
			k = dtt_pkg::KIND_SPACE;
		end else if (c > dtt_pkg::CH_SPACE && c <= dtt_pkg::CH_TILDE) begin
			k = dtt_pkg::KIND_PUNCT;
		end else begin
			k = dtt_pkg::KIND_OTHER;
		end
		return k;
	endfunction

	function automatic dtt_pkg::tok_class_t class_for_state(input dtt_pkg::scan_state_t st);
		dtt_pkg::tok_class_t cls;
		case (st)
			dtt_pkg::ST_LETTERS: cls = dtt_pkg::CLS_LETTER;
			dtt_pkg::ST_PUNCT:   cls = dtt_pkg::CLS_PUNCT;
			dtt_pkg::ST_SPACE:   cls = dtt_pkg::CLS_SPACE;
			default:             cls = dtt_pkg::CLS_NUMBER;
		endcase
		return cls;
	endfunction

	function automatic lexeme_byte_t lexeme(input logic [7:0] c,
		input dtt_pkg::tok_class_t cls, input logic start);
		lexeme_byte_t b;
		b.chr   = c;
		b.cls   = cls;
		b.start = start;
		b.last  = 1'b0;
		return b;
	endfunction

	// Advances the lexer state by one byte and queues the token bytes it yields.
	task automatic scan_byte(input logic [7:0] c, input logic eot);
		lexeme_byte_t         got[2];
		int                   n;
		dtt_pkg::scan_state_t st;
		dtt_pkg::scan_state_t nx;
		dtt_pkg::byte_kind_t  k;
		logic                 handled;
		logic                 joins;
		n       = 0;
		st      = lex_state;
		k       = kind_of_byte(c);
		handled = 1'b0;
		joins   = 1'b0;
		nx      = dtt_pkg::ST_START;
		if (st == dtt_pkg::ST_HELD_DOT) begin
			if (k == dtt_pkg::KIND_DIGIT) begin
				got[0]  = lexeme(dtt_pkg::CH_DOT, dtt_pkg::CLS_NUMBER, 1'b0);
				got[1]  = lexeme(c, dtt_pkg::CLS_NUMBER, 1'b0);
				n       = 2;
				st      = dtt_pkg::ST_FRAC;
				handled = 1'b1;
			end else begin
				// The dot becomes a punctuation token and the byte is scanned on from there.
				got[0] = lexeme(dtt_pkg::CH_DOT, dtt_pkg::CLS_PUNCT, 1'b1);
				n      = 1;
				st     = dtt_pkg::ST_PUNCT;
			end
		end
		if (!handled) begin
			case (st)
				dtt_pkg::ST_LETTERS: begin
					joins = (k == dtt_pkg::KIND_LETTER);
					nx    = dtt_pkg::ST_LETTERS;
				end
				dtt_pkg::ST_PUNCT: begin
					joins = (k == dtt_pkg::KIND_PUNCT);
					nx    = dtt_pkg::ST_PUNCT;
				end
				dtt_pkg::ST_SPACE: begin
					joins = (k == dtt_pkg::KIND_SPACE);
					nx    = dtt_pkg::ST_SPACE;
				end
				dtt_pkg::ST_INT: begin
					if (k == dtt_pkg::KIND_DIGIT) begin
						joins = 1'b1;
						nx    = dtt_pkg::ST_INT;
					end else if (c == dtt_pkg::CH_DOT) begin
						joins = 1'b1;
						nx    = dtt_pkg::ST_HELD_DOT;
					end
				end
				dtt_pkg::ST_FRAC: begin
					joins = (k == dtt_pkg::KIND_DIGIT);
					nx    = dtt_pkg::ST_FRAC;
				end
				default: joins = 1'b0;
			endcase
			if (joins) begin
				if (nx != dtt_pkg::ST_HELD_DOT) begin
					got[n] = lexeme(c, class_for_state(nx), 1'b0);
					n++;
				end
				st = nx;
			end else begin
				case (k)
					dtt_pkg::KIND_LETTER: nx = dtt_pkg::ST_LETTERS;
					dtt_pkg::KIND_DIGIT:  nx = dtt_pkg::ST_INT;
					dtt_pkg::KIND_PUNCT:  nx = dtt_pkg::ST_PUNCT;
					dtt_pkg::KIND_SPACE:  nx = dtt_pkg::ST_SPACE;
					default:              nx = dtt_pkg::ST_START;
				endcase
				if (nx != dtt_pkg::ST_START) begin
					got[n] = lexeme(c, class_for_state(nx), 1'b1);
					n++;
				end
				st = nx;
			end
		end
		if (eot) begin
			if (st == dtt_pkg::ST_HELD_DOT) begin
				got[n] = lexeme(dtt_pkg::CH_DOT, dtt_pkg::CLS_PUNCT, 1'b1);
				n++;
			end
			st = dtt_pkg::ST_START;
		end
		lex_state = st;
		if (n > 0) begin
			got[n - 1].last = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			expected_bytes.push_back(got[i]);
		end
	endtask

	function automatic logic [7:0] pick_byte(input dtt_pkg::byte_kind_t k);
		logic [7:0] b;
		int         r;
		case (k)
			dtt_pkg::KIND_LETTER: begin
				if ($urandom_range(1) == 1) begin
					b = 8'(dtt_pkg::CH_UP_A + $urandom_range(25));
				end else begin
					b = 8'(dtt_pkg::CH_LO_A + $urandom_range(25));
				end
			end
			dtt_pkg::KIND_DIGIT: b = 8'(dtt_pkg::CH_ZERO + $urandom_range(9));
			dtt_pkg::KIND_PUNCT: begin
				case ($urandom_range(3))
					0:       b = 8'(dtt_pkg::CH_BANG + $urandom_range(14));
					1:       b = 8'(dtt_pkg::CH_COLON + $urandom_range(6));
					2:       b = 8'(dtt_pkg::CH_LBRACK + $urandom_range(5));
					default: b = 8'(dtt_pkg::CH_LBRACE + $urandom_range(3));
				endcase
			end
			dtt_pkg::KIND_SPACE: begin
				r = $urandom_range(5);
				b = (r == 5) ? dtt_pkg::CH_SPACE : 8'(dtt_pkg::CH_TAB + r);
			end
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	task automatic add_byte(input logic [7:0] c, input logic eot);
		text_byte_t t;
		t.c   = c;
		t.eot = eot;
		text_queue.push_back(t);
	endtask

	task automatic add_text(input string s, input logic eot_at_end);
		for (int i = 0; i < s.len(); i++) begin
			add_byte(s[i], eot_at_end && (i == s.len() - 1));
		end
	endtask

	// Driver: presents bytes from the text queue and predicts at each transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				scan_byte(ch, end_of_text);
			end
			if (!push || !full) begin
				if (text_queue.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
					ch          <= text_queue[0].c;
					end_of_text <= text_queue[0].eot;
					void'(text_queue.pop_front());
					push        <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every result transfer against the oldest prediction.
	always @(posedge clk) begin
		lexeme_byte_t e;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("%0t: unexpected result: expected none,", $time,
							" actual chr=%h cls=%0d start=%b last=%b",
							out_char, token_class, token_start, last);
					end
				end else begin
					e = expected_bytes.pop_front();
					if (out_char !== e.chr || token_class !== e.cls ||
						token_start !== e.start || last !== e.last) begin
						error_count++;
						if (error_count <= MAX_REPORTS) begin
							$display("%0t: mismatch: expected chr=%h cls=%0d start=%b last=%b,",
								$time, e.chr, e.cls, e.start, e.last,
								" actual chr=%h cls=%0d start=%b last=%b",
								out_char, token_class, token_start, last);
						end
					end
				end
			end
			pop <= calm || ($urandom_range(99) >= 7);
		end
	end

	// Watchdog: ends the run if no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if ((push && !full) || (pop && !empty)) begin
				stall_count <= 0;
			end else if (stall_count >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				stall_count <= stall_count + 1;
			end
		end
	end

	initial begin
		int                  r;
		int                  len;
		dtt_pkg::byte_kind_t k;
		// Range extremes of every byte class, and dropped bytes at both ends.
		add_text("AzZa", 1'b0);
		add_byte(8'h00, 1'b0);
		// Held dot followed by a digit, then by punctuation.
		add_text("9.0", 1'b0);
		add_text("1.!", 1'b0);
		add_text("/:@[`{~", 1'b0);
		add_byte(dtt_pkg::CH_SPACE, 1'b0);
		add_byte(dtt_pkg::CH_TAB, 1'b0);
		add_byte(8'h0A, 1'b0);
		add_byte(8'h0B, 1'b0);
		add_byte(8'h0C, 1'b0);
		add_byte(dtt_pkg::CH_CR, 1'b0);
		// Held dot flushed at end of text, and held dot before a dropped byte.
		add_text("5.", 1'b1);
		add_text("3.", 1'b0);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h7F, 1'b0);
		add_byte(8'h80, 1'b0);

		while (text_queue.size() < RANDOM_BYTES) begin
			r = $urandom_range(99);
			if (r < 12) begin
				add_byte(pick_byte(dtt_pkg::KIND_OTHER), $urandom_range(99) < 3);
			end else if (r < 45) begin
				len = $urandom_range(4, 1);
				for (int i = 0; i < len; i++) begin
					add_byte(pick_byte(dtt_pkg::KIND_DIGIT), $urandom_range(99) < 3);
				end
				if ($urandom_range(1) == 1) begin
					add_byte(dtt_pkg::CH_DOT, $urandom_range(99) < 3);
					if ($urandom_range(99) < 70) begin
						len = $urandom_range(3, 1);
						for (int i = 0; i < len; i++) begin
							add_byte(pick_byte(dtt_pkg::KIND_DIGIT),
								$urandom_range(99) < 3);
						end
					end
				end
			end else begin
				case ($urandom_range(2))
					0:       k = dtt_pkg::KIND_LETTER;
					1:       k = dtt_pkg::KIND_PUNCT;
					default: k = dtt_pkg::KIND_SPACE;
				endcase
				len = $urandom_range(6, 1);
				for (int i = 0; i < len; i++) begin
					add_byte(pick_byte(k), $urandom_range(99) < 3);
				end
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (text_queue.size() != 0 || push) @(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
